### rtl/tenf_pkg.sv
package tenf_pkg;

  localparam int unsigned MaxTriangles = 1024;
  localparam int unsigned VertexBits   = 16;
  localparam int unsigned EntryBits    = 3 * VertexBits;
  localparam int unsigned IdxW         = $clog2(MaxTriangles);
  localparam int unsigned CountW       = $clog2(MaxTriangles + 1);
  localparam int unsigned FaceW        = 10;
  localparam int unsigned ActionW      = 2;

  localparam logic [ActionW-1:0] ActLoad  = 2'd0;
  localparam logic [ActionW-1:0] ActQuery = 2'd1;
  localparam logic [ActionW-1:0] ActClear = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StQuery,
    StScan,
    StFinish
  } state_e;

  typedef struct packed {
    logic             has_bc;
    logic [FaceW-1:0] neighbour_bc;
    logic             has_ac;
    logic [FaceW-1:0] neighbour_ac;
    logic             has_ab;
    logic [FaceW-1:0] neighbour_ab;
  } result_t;

endpackage

### rtl/triangle_edge_neighbour_finder_unit.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser: action; tdata: vertices, face index
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tuser: bad_index; tdata: three neighbours
//
// A load or a clear item is handled in the idle state. A query item reads its own triangle,
// then scans all N stored triangles: the triangle store has one read port and the scan reads one
// triangle per cycle. A query with an out-of-range index skips the scan and goes straight to finish.
// Reset clears the triangle count and all control state; the store contents are not cleared.
// The input is stalled while a query runs; loads and clears are still taken while a result
// waits in the output register, and a finished query waits in StFinish until the output is free.
module triangle_edge_neighbour_finder_unit
  import tenf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] vertex_a, [31:16] vertex_b, [47:32] vertex_c, [57:48] query_face, rest zero
  input  logic [63:0] s_axis_tdata_i,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [9:0] neighbour_ab, [10] has_ab, [20:11] neighbour_ac, [21] has_ac,
  // [31:22] neighbour_bc, [32] has_bc, rest zero
  output logic [39:0] m_axis_tdata_o,
  // [0] bad_index
  output logic        m_axis_tuser_o
);

  state_e state_q, state_d;

  logic [CountW-1:0]    total_q, total_d;
  logic [CountW-1:0]    rd_cnt_q, rd_cnt_d;
  logic                 pend_q, pend_d;
  logic [IdxW-1:0]      pend_idx_q, pend_idx_d;
  logic [IdxW-1:0]      query_q, query_d;
  logic                 bad_q, bad_d;
  logic [VertexBits-1:0] va_q, va_d, vb_q, vb_d, vc_q, vc_d;
  result_t              acc_q, acc_d;

  logic                 out_valid_q, out_valid_d;
  result_t              out_res_q, out_res_d;
  logic                 out_bad_q, out_bad_d;

  logic                  in_fire;
  logic [ActionW-1:0]    action;
  logic [VertexBits-1:0] in_va, in_vb, in_vc;
  logic [FaceW-1:0]      in_face;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [EntryBits-1:0]  ram_wdata;
  logic [IdxW-1:0]       ram_raddr;
  logic [EntryBits-1:0]  ram_rdata;

  logic [VertexBits-1:0] t0, t1, t2;
  logic                  hold_a, hold_b, hold_c;

  assign action  = s_axis_tuser_i;
  assign in_va   = s_axis_tdata_i[VertexBits-1:0];
  assign in_vb   = s_axis_tdata_i[2*VertexBits-1:VertexBits];
  assign in_vc   = s_axis_tdata_i[3*VertexBits-1:2*VertexBits];
  assign in_face = s_axis_tdata_i[48 +: FaceW];

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Loads write only while idle and the scan reads only during a query, so a scan read never meets a
  // write; the idle read at the face field may hit the entry being written, but only a query uses it.
  assign ram_we    = in_fire && (action == ActLoad) && (total_q < CountW'(MaxTriangles));
  assign ram_waddr = total_q[IdxW-1:0];
  assign ram_wdata = {in_vc, in_vb, in_va};
  assign ram_raddr = (state_q == StIdle) ? IdxW'(in_face) : rd_cnt_q[IdxW-1:0];

  tenf_ram #(
    .Width (EntryBits),
    .Depth (MaxTriangles)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (1'b1),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Membership of each query vertex in the triangle read back from the store.
  assign t0     = ram_rdata[VertexBits-1:0];
  assign t1     = ram_rdata[2*VertexBits-1:VertexBits];
  assign t2     = ram_rdata[3*VertexBits-1:2*VertexBits];
  assign hold_a = (t0 == va_q) || (t1 == va_q) || (t2 == va_q);
  assign hold_b = (t0 == vb_q) || (t1 == vb_q) || (t2 == vb_q);
  assign hold_c = (t0 == vc_q) || (t1 == vc_q) || (t2 == vc_q);

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    rd_cnt_d    = rd_cnt_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    query_d     = query_q;
    bad_d       = bad_q;
    va_d        = va_q;
    vb_d        = vb_q;
    vc_d        = vc_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_bad_d   = out_bad_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (action)
            ActLoad: begin
              if (ram_we) begin
                total_d = total_q + CountW'(1);
              end
            end
            ActClear: begin
              total_d = '0;
            end
            ActQuery: begin
              query_d  = IdxW'(in_face);
              bad_d    = (CountW'(in_face) >= total_q);
              acc_d    = '0;
              rd_cnt_d = '0;
              pend_d   = 1'b0;
              state_d  = (CountW'(in_face) >= total_q) ? StFinish : StQuery;
            end
            default: begin
            end
          endcase
        end
      end
      StQuery: begin
        // The query's own triangle arrives now; the read of entry zero goes out.
        va_d       = ram_rdata[VertexBits-1:0];
        vb_d       = ram_rdata[2*VertexBits-1:VertexBits];
        vc_d       = ram_rdata[3*VertexBits-1:2*VertexBits];
        pend_d     = 1'b1;
        pend_idx_d = '0;
        rd_cnt_d   = CountW'(1);
        state_d    = StScan;
      end
      StScan: begin
        if (pend_q && (pend_idx_q != query_q)) begin
          // A later match overwrites an earlier one, so the last in scan order wins.
          if (hold_a && hold_b) begin
            acc_d.has_ab       = 1'b1;
            acc_d.neighbour_ab = FaceW'(pend_idx_q);
          end
          if (hold_a && hold_c) begin
            acc_d.has_ac       = 1'b1;
            acc_d.neighbour_ac = FaceW'(pend_idx_q);
          end
          if (hold_b && hold_c) begin
            acc_d.has_bc       = 1'b1;
            acc_d.neighbour_bc = FaceW'(pend_idx_q);
          end
        end
        if (rd_cnt_q < total_q) begin
          pend_d     = 1'b1;
          pend_idx_d = rd_cnt_q[IdxW-1:0];
          rd_cnt_d   = rd_cnt_q + CountW'(1);
        end else begin
          pend_d  = 1'b0;
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = acc_q;
          out_bad_d   = bad_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      total_q     <= '0;
      rd_cnt_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      rd_cnt_q    <= rd_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    query_q    <= query_d;
    bad_q      <= bad_d;
    va_q       <= va_d;
    vb_q       <= vb_d;
    vc_q       <= vc_d;
    acc_q      <= acc_d;
    out_res_q  <= out_res_d;
    out_bad_q  <= out_bad_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_res_q};
  assign m_axis_tuser_o  = out_bad_q;

endmodule

### rtl/tenf_ram.sv
module tenf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/tb_triangle_edge_neighbour_finder_unit.sv
`timescale 1ns / 100ps

module tb_triangle_edge_neighbour_finder_unit;
  import tenf_pkg::*;

  // The only action code that the block does not define. Items carrying it are ignored.
  localparam logic [ActionW-1:0] ActUnused = 2'd3;

  localparam int unsigned ResultBits  = $bits(result_t);
  localparam int unsigned ItemTarget  = 580;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = MaxTriangles + 8;
  localparam int unsigned CycleLimit  = 400000;

  // One predicted answer: the neighbour fields as the port packs them, plus the
  // out-of-range flag that travels on tuser.
  typedef struct packed {
    logic    bad;
    result_t res;
  } answer_t;

  // One input item. When fixed is set, the answer is written into the table by hand
  // and replaces the predicted one.
  typedef struct packed {
    logic [ActionW-1:0]    action;
    logic [VertexBits-1:0] va;
    logic [VertexBits-1:0] vb;
    logic [VertexBits-1:0] vc;
    logic [FaceW-1:0]      face;
    logic                  fixed;
    answer_t               want;
  } stim_t;

  logic        clk    = 1'b0;
  logic        rst_n  = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  // The item currently offered. The slave-side data is built from it, so it is
  // always known, even before the first item.
  stim_t offer = '0;

  assign s_tdata = {6'b0, offer.face, offer.vc, offer.vb, offer.va};
  assign s_tuser = offer.action;

  triangle_edge_neighbour_finder_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Behavioural copy of the triangle table and the neighbour scan.
  // ---------------------------------------------------------------------------
  logic [VertexBits-1:0] mesh_vtx [MaxTriangles][3];
  int                    mesh_count = 0;
  answer_t               answer_q [$];

  int          mismatches   = 0;
  int          items_sent   = 0;
  int unsigned cycle_count  = 0;
  bit          steady       = 1'b0;
  bit          stall_done   = 1'b0;
  int          hold_left    = 0;

  // True when stored triangle idx holds both ends of the edge p-q. A degenerate
  // edge (p equal to q) therefore matches any triangle holding that vertex.
  function automatic bit holds_edge(input int idx, input logic [VertexBits-1:0] p,
                                    input logic [VertexBits-1:0] q);
    bit has_p;
    bit has_q;
    has_p = (mesh_vtx[idx][0] == p) || (mesh_vtx[idx][1] == p) || (mesh_vtx[idx][2] == p);
    has_q = (mesh_vtx[idx][0] == q) || (mesh_vtx[idx][1] == q) || (mesh_vtx[idx][2] == q);
    return has_p && has_q;
  endfunction

  // Scans every other stored triangle in index order; a later match overwrites an
  // earlier one, so the last matching triangle wins for each edge.
  function automatic answer_t scan_neighbours(input logic [FaceW-1:0] face);
    answer_t               ans;
    logic [VertexBits-1:0] qa;
    logic [VertexBits-1:0] qb;
    logic [VertexBits-1:0] qc;
    ans = '0;
    if (face >= mesh_count) begin
      ans.bad = 1'b1;
      return ans;
    end
    qa = mesh_vtx[face][0];
    qb = mesh_vtx[face][1];
    qc = mesh_vtx[face][2];
    for (int i = 0; i < mesh_count; i++) begin
      if (i != face) begin
        if (holds_edge(i, qa, qb)) begin
          ans.res.has_ab       = 1'b1;
          ans.res.neighbour_ab = FaceW'(i);
        end
        if (holds_edge(i, qa, qc)) begin
          ans.res.has_ac       = 1'b1;
          ans.res.neighbour_ac = FaceW'(i);
        end
        if (holds_edge(i, qb, qc)) begin
          ans.res.has_bc       = 1'b1;
          ans.res.neighbour_bc = FaceW'(i);
        end
      end
    end
    return ans;
  endfunction

  // Applies one accepted item to the table copy and queues the answer it causes.
  function automatic void absorb_item(input stim_t it);
    case (it.action)
      ActLoad: begin
        // A load into a full table is dropped.
        if (mesh_count < MaxTriangles) begin
          mesh_vtx[mesh_count][0] = it.va;
          mesh_vtx[mesh_count][1] = it.vb;
          mesh_vtx[mesh_count][2] = it.vc;
          mesh_count++;
        end
      end
      ActClear: mesh_count = 0;
      ActQuery: begin
        if (it.fixed) answer_q.push_back(it.want);
        else answer_q.push_back(scan_neighbours(it.face));
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Handshake monitor. Both sides are sampled at the rising edge, before the block
  // updates, so the values seen are the ones that made the handshake.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    answer_t want;
    result_t got;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (answer_q.size() == 0) begin
          flag_mismatch("result with none outstanding", 1, 0);
        end else begin
          want = answer_q.pop_front();
          got  = m_tdata[ResultBits-1:0];
          if (got.neighbour_ab !== want.res.neighbour_ab)
            flag_mismatch("neighbour_ab", got.neighbour_ab, want.res.neighbour_ab);
          if (got.has_ab !== want.res.has_ab)
            flag_mismatch("has_ab", got.has_ab, want.res.has_ab);
          if (got.neighbour_ac !== want.res.neighbour_ac)
            flag_mismatch("neighbour_ac", got.neighbour_ac, want.res.neighbour_ac);
          if (got.has_ac !== want.res.has_ac)
            flag_mismatch("has_ac", got.has_ac, want.res.has_ac);
          if (got.neighbour_bc !== want.res.neighbour_bc)
            flag_mismatch("neighbour_bc", got.neighbour_bc, want.res.neighbour_bc);
          if (got.has_bc !== want.res.has_bc)
            flag_mismatch("has_bc", got.has_bc, want.res.has_bc);
          if (m_tuser !== want.bad)
            flag_mismatch("bad_index", m_tuser, want.bad);
          if (m_tdata[39:ResultBits] !== '0)
            flag_mismatch("tdata padding", m_tdata[39:ResultBits], 0);
        end
      end
      if (s_valid && s_ready) absorb_item(offer);
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. It stalls about a quarter of the time, never during the
  // steady stretch, and once, early in the random part, holds off for a long run
  // of cycles so that a result sits in the output register and later queries back
  // up to the input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!stall_done && (items_sent >= 60)) begin
      stall_done = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders. Fields that an action does not use are filled at random or with a
  // given value, so that those input bits are exercised without affecting the behaviour.
  // ---------------------------------------------------------------------------
  function automatic stim_t load_row(input logic [VertexBits-1:0] a,
                                     input logic [VertexBits-1:0] b,
                                     input logic [VertexBits-1:0] c);
    stim_t it;
    it        = '0;
    it.action = ActLoad;
    it.va     = a;
    it.vb     = b;
    it.vc     = c;
    it.face   = FaceW'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic stim_t query_row(input logic [FaceW-1:0] face);
    stim_t it;
    it        = '0;
    it.action = ActQuery;
    it.va     = VertexBits'($urandom_range(0, 65535));
    it.vb     = VertexBits'($urandom_range(0, 65535));
    it.vc     = VertexBits'($urandom_range(0, 65535));
    it.face   = face;
    return it;
  endfunction

  // A query whose answer is plain: either out of range, or a triangle with no
  // neighbour at all, so every neighbour field is zero.
  function automatic stim_t query_fixed(input logic [FaceW-1:0] face, input logic bad);
    stim_t it;
    it          = query_row(face);
    it.fixed    = 1'b1;
    it.want     = '0;
    it.want.bad = bad;
    return it;
  endfunction

  function automatic stim_t plain_row(input logic [ActionW-1:0] action,
                                      input logic [VertexBits-1:0] v,
                                      input logic [FaceW-1:0] face);
    stim_t it;
    it        = '0;
    it.action = action;
    it.va     = v;
    it.vb     = v;
    it.vc     = v;
    it.face   = face;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Item sender. It is entered at a falling edge, may idle with valid low for a while, then
  // holds the item until it is taken, and returns at the next falling edge.
  // ---------------------------------------------------------------------------
  task automatic push_item(input stim_t it);
    while (!steady && ($urandom_range(0, 99) < 25)) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    offer   <= it;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
    if (it.action != ActUnused) items_sent++;
  endtask

  logic [VertexBits-1:0] vpool [48];
  int                    pool_n;

  function automatic void fill_pool(input int n);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) vpool[i] = $urandom_range(0, 1) ? '1 : '0;
      else vpool[i] = VertexBits'($urandom_range(0, 65535));
    end
  endfunction

  function automatic logic [VertexBits-1:0] pool_vertex();
    return vpool[$urandom_range(0, pool_n - 1)];
  endfunction

  // One well-formed run: perhaps a clear, a few loads drawn from a small set of
  // shared vertices so that edges coincide, then a few queries, mostly in range.
  // Now and then a load with unrelated vertices or an unused action is mixed in.
  task automatic run_episode();
    int          loads;
    int          queries;
    logic [FaceW-1:0] face;
    if ((mesh_count > 40) || ($urandom_range(0, 7) == 0))
      push_item(plain_row(ActClear, VertexBits'($urandom_range(0, 65535)),
                          FaceW'($urandom_range(0, 1023))));
    fill_pool($urandom_range(3, 10));
    loads = $urandom_range(1, 8);
    repeat (loads) begin
      if ($urandom_range(0, 9) == 0)
        push_item(load_row(VertexBits'($urandom_range(0, 65535)),
                           VertexBits'($urandom_range(0, 65535)),
                           VertexBits'($urandom_range(0, 65535))));
      else
        push_item(load_row(pool_vertex(), pool_vertex(), pool_vertex()));
    end
    queries = $urandom_range(1, 4);
    repeat (queries) begin
      if ($urandom_range(0, 7) == 0) face = FaceW'($urandom_range(0, 1023));
      else face = FaceW'($urandom_range(0, mesh_count - 1));
      push_item(query_row(face));
    end
    if ($urandom_range(0, 9) == 0)
      push_item(plain_row(ActUnused, VertexBits'($urandom_range(0, 65535)),
                          FaceW'($urandom_range(0, 1023))));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  stim_t directed_rows [24];

  initial begin
    // Directed part. Triangle 2 is (1,2,3); triangles 3, 4 and 5 each share a
    // different edge with it, and triangle 6 repeats it, so it must win on every edge.
    // Triangle 7 is degenerate, with its first two vertices equal.
    directed_rows[0]  = query_fixed('0, 1'b1);                    // empty after reset
    directed_rows[1]  = query_fixed('1, 1'b1);                    // highest index, empty
    directed_rows[2]  = plain_row(ActClear, '0, '0);              // clear when empty
    directed_rows[3]  = plain_row(ActUnused, '0, '0);             // ignored action
    directed_rows[4]  = load_row('0, '0, '0);
    directed_rows[5]  = load_row('1, '1, '1);
    directed_rows[6]  = query_fixed(10'd0, 1'b0);                 // no shared vertex
    directed_rows[7]  = query_fixed(10'd2, 1'b1);                 // just past the end
    directed_rows[8]  = load_row(16'd1, 16'd2, 16'd3);
    directed_rows[9]  = load_row(16'd2, 16'd1, 16'd4);
    directed_rows[10] = load_row(16'd3, 16'd1, 16'd9);
    directed_rows[11] = load_row(16'd2, 16'd3, 16'd7);
    directed_rows[12] = load_row(16'd3, 16'd2, 16'd1);
    directed_rows[13] = query_row(10'd2);
    directed_rows[14] = query_row(10'd6);
    directed_rows[15] = load_row(16'd5, 16'd5, 16'd6);
    directed_rows[16] = load_row(16'd5, 16'd8, 16'd9);
    directed_rows[17] = query_row(10'd7);
    directed_rows[18] = plain_row(ActUnused, '1, '1);             // ignored, all ones
    directed_rows[19] = query_fixed('1, 1'b1);
    directed_rows[20] = plain_row(ActClear, '1, '1);
    directed_rows[21] = query_fixed('0, 1'b1);                    // gone after clear
    directed_rows[22] = load_row(16'hAAAA, 16'h5555, 16'h1234);
    directed_rows[23] = query_fixed('0, 1'b0);                    // alone in the table

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) push_item(directed_rows[i]);

    // Random part. A steady stretch without idling on either side falls in the
    // middle, and early on the receiver holds off for a long stretch.
    while (items_sent < ItemTarget) begin
      steady = (items_sent >= 250) && (items_sent < 350);
      run_episode();
    end
    steady = 1'b0;
    s_valid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
